### hw/rtl/tgpm_pkg.sv
package tgpm_pkg;

    // word width of both operands and of the product
    localparam int WORD_W         = 32;
    localparam int POLY_WORDS_DEF = 256;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_LAST,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;   // store the incoming pair, seed the accumulator
        logic issue;    // read one pair of stored words, step the counter
        logic finish;   // load the output register, advance the index
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic cnt_done; // counter has reached the current index
        logic out_free; // output register can take a new word
    } t_sts;

endpackage

### hw/rtl/tgpm_ram.sv
module tgpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/tgpm_dp.sv
module tgpm_dp import tgpm_pkg::*; #(
    parameter int POLY_WORDS = POLY_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [WORD_W-1:0] i_a_word,
    input  logic [WORD_W-1:0] i_b_word,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [WORD_W-1:0] o_product_word,
    output logic              o_last_word
);

    localparam int IDX_W = $clog2(POLY_WORDS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POLY_WORDS - 1);

    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_cnt;
    logic [WORD_W-1:0]   r_carry;
    logic [WORD_W-1:0]   r_acc_lo;
    logic [WORD_W-1:0]   r_acc_hi;
    logic                r_rd_vld;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_data;
    logic                r_out_last;
    logic [WORD_W-1:0]   w_a_rd;
    logic [WORD_W-1:0]   w_b_rd;
    logic [2*WORD_W-1:0] w_prod;
    logic                w_is_last;

    // 32x32 carry-less product: xor of shifted partial products
    function automatic logic [2*WORD_W-1:0] clmul(input logic [WORD_W-1:0] x,
                                                  input logic [WORD_W-1:0] y);
        logic [2*WORD_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (y[b]) begin
                acc = acc ^ ({{WORD_W{1'b0}}, x} << b);
            end
        end
        return acc;
    endfunction

    tgpm_ram #(.WIDTH(WORD_W), .DEPTH(POLY_WORDS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (r_idx),
        .i_wdata (i_a_word),
        .i_raddr (r_cnt),
        .o_rdata (w_a_rd)
    );

    tgpm_ram #(.WIDTH(WORD_W), .DEPTH(POLY_WORDS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (r_idx),
        .i_wdata (i_b_word),
        .i_raddr (r_idx - r_cnt),
        .o_rdata (w_b_rd)
    );

    assign w_prod    = clmul(w_a_rd, w_b_rd);
    assign w_is_last = (r_idx == LAST_IDX);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_carry     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.finish) begin
                r_idx   <= w_is_last ? '0 : r_idx + 1'b1;
                r_carry <= w_is_last ? '0 : r_acc_hi;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cnt <= '0;
        end else if (i_cmd.issue) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.accept) begin
            r_acc_lo <= r_carry;
            r_acc_hi <= '0;
        end else if (r_rd_vld) begin
            r_acc_lo <= r_acc_lo ^ w_prod[WORD_W-1:0];
            r_acc_hi <= r_acc_hi ^ w_prod[2*WORD_W-1:WORD_W];
        end
        if (i_cmd.finish) begin
            r_out_data <= r_acc_lo;
            r_out_last <= w_is_last;
        end
    end

    assign o_sts.cnt_done = (r_cnt == r_idx);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_product_word = r_out_data;
    assign o_last_word    = r_out_last;

endmodule

### hw/rtl/tgpm_ctrl.sv
module tgpm_ctrl import tgpm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_sts   i_sts,
    output t_cmd   o_cmd,
    output t_state o_state
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_RUN;
            S_RUN:  if (i_sts.cnt_done) n_state = S_LAST;
            S_LAST: n_state = S_DONE;
            S_DONE: if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_RUN:  o_cmd.issue  = 1'b1;
            S_LAST: o_cmd        = '0;
            S_DONE: o_cmd.finish = i_sts.out_free;
            default: o_cmd       = '0;
        endcase
    end

    assign o_state = r_state;

endmodule

### hw/rtl/truncated_gf2_poly_multiplier_core.sv
// the pair at index k passes run (one read per term), last accumulate and done; its product word is then registered
// a new pair is taken only after the previous product word is loaded, which waits while the output register is full
// terms go one at a time through the single carry-less 32x32 unit and the one read port per operand store
// the next pair is taken while a finished word still waits in the output register
// reset (synchronous, active low) abandons a partial product; the next pair is index 0
// operand stores are not cleared; every entry is written before it is read
module truncated_gf2_poly_multiplier_core import tgpm_pkg::*; #(
    parameter int POLY_WORDS = POLY_WORDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input pair stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [2*WORD_W-1:0] i_s_axis_tdata,  // a_word [31:0], b_word [63:32]
    // product word stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [WORD_W-1:0]   o_m_axis_tdata,  // product_word [31:0]
    output logic                o_m_axis_tlast   // last_word
);

    t_cmd   w_cmd;
    t_sts   w_sts;
    t_state w_state;

    // controller: idle -> run (one read per term) -> last accumulate -> done
    tgpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    // datapath: operand stores, shared carry-less unit, accumulator, output register
    tgpm_dp #(.POLY_WORDS(POLY_WORDS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_a_word       (i_s_axis_tdata[WORD_W-1:0]),
        .i_b_word       (i_s_axis_tdata[2*WORD_W-1:WORD_W]),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_product_word (o_m_axis_tdata),
        .o_last_word    (o_m_axis_tlast)
    );

`ifndef SYNTH
    // one pair at a time: no second transaction right after an accepted one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while a pair is in work");

    // a new product word appears only after the controller finished an item
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_cmd.finish))
        else $error("output valid without a finished item");

    // the output register is loaded only when its word is gone or leaving
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("pending product word overwritten");

    // accepting happens only in the idle state
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |-> (w_state == S_IDLE) && !w_cmd.issue && !w_cmd.finish)
        else $error("accept outside idle");
`endif

endmodule
